/* rtl/sbst_pkg.sv */
// ----------------------------------------------------------------------------
// sbst_pkg
// Shared types and constants for the 2D segment versus box slab test.
// ----------------------------------------------------------------------------
package sbst_pkg;

  localparam int CW = 16;             // coordinate width
  localparam int FB = 16;             // fraction bits of the Q format
  localparam int QW = FB + 3;         // signed quotient width, holds [-2,2]
  localparam int CFG_IW = 3;          // config index width

  // quotient magnitude bits produced by the long division
  localparam int DIV_STEPS = FB + 1;
  localparam int STEPS_PER_STG = 3;
  localparam int DIV_STG = (DIV_STEPS + STEPS_PER_STG - 1) / STEPS_PER_STG;
  // divider stages plus the sign fix-up register
  localparam int DIV_LAT = DIV_STG + 1;

  localparam logic [CFG_IW-1:0] REG_MIN_X = 3'd0;
  localparam logic [CFG_IW-1:0] REG_MIN_Y = 3'd1;
  localparam logic [CFG_IW-1:0] REG_MAX_X = 3'd2;
  localparam logic [CFG_IW-1:0] REG_MAX_Y = 3'd3;

  typedef struct packed {
    logic signed [CW-1:0] start_x;
    logic signed [CW-1:0] start_y;
    logic signed [CW-1:0] end_x;
    logic signed [CW-1:0] end_y;
  } in_t;

  typedef struct packed {
    logic          hit;
    logic [FB:0]   entry_param;
  } out_t;

  // per-axis flags that travel beside the dividers
  typedef struct packed {
    logic dz_x;
    logic pass_x;
    logic dz_y;
    logic pass_y;
  } side_t;

  // running parameter interval
  typedef struct packed {
    logic                 ok;
    logic signed [QW-1:0] enter;
    logic signed [QW-1:0] leave;
  } ivl_t;

endpackage

/* rtl/sbst_div.sv */
// ----------------------------------------------------------------------------
// sbst_div
// Pipelined restoring divider: floor(+-mag * 2^FB / den), saturated to [-2,2].
// ----------------------------------------------------------------------------
module sbst_div (
  input  logic                          clk_i,
  input  logic                          en_i,
  input  logic [sbst_pkg::CW-1:0]       mag_i,
  input  logic [sbst_pkg::CW-1:0]       den_i,
  input  logic                          neg_i,
  input  logic                          sat_i,
  output logic signed [sbst_pkg::QW-1:0] quo_o
);
  import sbst_pkg::*;

  logic [CW-1:0] rem_q [DIV_STG];
  logic [FB:0]   qm_q  [DIV_STG];
  logic [CW-1:0] den_q [DIV_STG];
  logic          neg_q [DIV_STG];
  logic          sat_q [DIV_STG];
  logic signed [QW-1:0] quo_q;

  for (genvar s = 0; s < DIV_STG; s++) begin : g_stg
    logic [CW-1:0] rem_in;
    logic [CW-1:0] den_in;
    logic [FB:0]   qm_in;
    logic          neg_in;
    logic          sat_in;
    logic          bit0;
    logic [CW-1:0] rem_d;
    logic [FB:0]   qm_d;

    if (s == 0) begin : g_first
      // first step brings in the low bit of the magnitude
      assign rem_in = {1'b0, mag_i[CW-1:1]};
      assign bit0   = mag_i[0];
      assign den_in = den_i;
      assign qm_in  = '0;
      assign neg_in = neg_i;
      assign sat_in = sat_i;
    end else begin : g_next
      assign rem_in = rem_q[s-1];
      assign bit0   = 1'b0;
      assign den_in = den_q[s-1];
      assign qm_in  = qm_q[s-1];
      assign neg_in = neg_q[s-1];
      assign sat_in = sat_q[s-1];
    end

    always_comb begin
      logic [CW:0]   t;
      logic [CW-1:0] r;
      logic [FB:0]   q;
      r = rem_in;
      q = qm_in;
      for (int j = 0; j < STEPS_PER_STG; j++) begin
        if (s * STEPS_PER_STG + j < DIV_STEPS) begin
          t = {r, ((s * STEPS_PER_STG + j) == 0) ? bit0 : 1'b0};
          if (t >= {1'b0, den_in}) begin
            t = t - {1'b0, den_in};
            q = {q[FB-1:0], 1'b1};
          end else begin
            q = {q[FB-1:0], 1'b0};
          end
          r = t[CW-1:0];
        end
      end
      rem_d = r;
      qm_d  = q;
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[s] <= rem_d;
        qm_q[s]  <= qm_d;
        den_q[s] <= den_in;
        neg_q[s] <= neg_in;
        sat_q[s] <= sat_in;
      end
    end
  end

  // round toward minus infinity and apply sign and saturation
  logic [FB+1:0]        qv;
  logic signed [QW-1:0] quo_d;

  always_comb begin
    if (sat_q[DIV_STG-1]) begin
      qv = {1'b1, {(FB+1){1'b0}}};
    end else begin
      qv = {1'b0, qm_q[DIV_STG-1]}
         + {{(FB+1){1'b0}}, (neg_q[DIV_STG-1] && (rem_q[DIV_STG-1] != '0))};
    end
    if (neg_q[DIV_STG-1]) begin
      quo_d = -$signed({1'b0, qv});
    end else begin
      quo_d = $signed({1'b0, qv});
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      quo_q <= quo_d;
    end
  end

  assign quo_o = quo_q;

endmodule

/* rtl/segment_box_slab_test_2d.sv */
// ----------------------------------------------------------------------------
// segment_box_slab_test_2d
// Slab test of a 2D segment against a box held in four config registers.
// ----------------------------------------------------------------------------
// Path: stage 1, divider stages, sign fix-up, x axis, output register.
// Throughput: one word per cycle unless the output word is held; the four
// quotient dividers each resolve up to three quotient bits per stage.
// Reset clears the box registers to zero and empties the pipeline.
module segment_box_slab_test_2d (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  sbst_pkg::in_t             in_data_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output sbst_pkg::out_t            out_data_o,
  input  logic                      cfg_valid_i,
  output logic                      cfg_ready_o,
  input  logic [sbst_pkg::CFG_IW-1:0] cfg_index_i,
  input  logic [sbst_pkg::CW-1:0]   cfg_data_i
);
  import sbst_pkg::*;

  localparam int NL = 4;  // lanes: x low, x high, y low, y high

  logic signed [CW-1:0] min_x_q, min_y_q, max_x_q, max_y_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_x_q <= '0;
      min_y_q <= '0;
      max_x_q <= '0;
      max_y_q <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_MIN_X: min_x_q <= cfg_data_i;
        REG_MIN_Y: min_y_q <= cfg_data_i;
        REG_MAX_X: max_x_q <= cfg_data_i;
        REG_MAX_Y: max_y_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // whole pipeline advances unless the output word is held
  logic adv;
  logic out_valid_q;
  assign adv        = !(out_valid_q && out_stall_i);
  assign in_stall_o = !adv;

  // ---------------- stage 1: differences, magnitudes, flags ----------------
  logic signed [CW:0] sx, sy, dx, dy;
  logic signed [CW:0] num [NL];
  logic [CW-1:0]      mag_d [NL];
  logic [CW-1:0]      den_d [NL];
  logic [NL-1:0]      neg_d, sat_d;
  logic [CW-1:0]      dxm, dym;
  side_t              side_d;

  always_comb begin
    sx = {in_data_i.start_x[CW-1], in_data_i.start_x};
    sy = {in_data_i.start_y[CW-1], in_data_i.start_y};
    dx = {in_data_i.end_x[CW-1], in_data_i.end_x} - sx;
    dy = {in_data_i.end_y[CW-1], in_data_i.end_y} - sy;
    num[0] = {min_x_q[CW-1], min_x_q} - sx;
    num[1] = {max_x_q[CW-1], max_x_q} - sx;
    num[2] = {min_y_q[CW-1], min_y_q} - sy;
    num[3] = {max_y_q[CW-1], max_y_q} - sy;
    dxm = dx[CW] ? CW'(-dx) : dx[CW-1:0];
    dym = dy[CW] ? CW'(-dy) : dy[CW-1:0];
    for (int l = 0; l < NL; l++) begin
      mag_d[l] = num[l][CW] ? CW'(-num[l]) : num[l][CW-1:0];
      den_d[l] = (l < 2) ? dxm : dym;
      neg_d[l] = num[l][CW] ^ ((l < 2) ? dx[CW] : dy[CW]);
      // |num| >= 2|d| means the quotient reaches the clamp
      sat_d[l] = {1'b0, mag_d[l]} >= {den_d[l], 1'b0};
    end
    side_d.dz_x   = (dx == '0);
    side_d.pass_x = !(num[0] > 0) && !(num[1] < 0);
    side_d.dz_y   = (dy == '0);
    side_d.pass_y = !(num[2] > 0) && !(num[3] < 0);
  end

  logic          v1_q;
  logic [CW-1:0] mag_q [NL];
  logic [CW-1:0] den_q [NL];
  logic [NL-1:0] neg_q, sat_q;
  side_t         side1_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (adv) begin
      v1_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      mag_q   <= mag_d;
      den_q   <= den_d;
      neg_q   <= neg_d;
      sat_q   <= sat_d;
      side1_q <= side_d;
    end
  end

  // ---------------- divider stages ----------------
  logic signed [QW-1:0] quo [NL];

  for (genvar l = 0; l < NL; l++) begin : g_lane
    sbst_div u_div (
      .clk_i (clk_i),
      .en_i  (adv),
      .mag_i (mag_q[l]),
      .den_i (den_q[l]),
      .neg_i (neg_q[l]),
      .sat_i (sat_q[l]),
      .quo_o (quo[l])
    );
  end

  logic  vd_q   [DIV_LAT];
  side_t sided_q[DIV_LAT];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < DIV_LAT; i++) vd_q[i] <= 1'b0;
    end else if (adv) begin
      vd_q[0] <= v1_q;
      for (int i = 1; i < DIV_LAT; i++) vd_q[i] <= vd_q[i-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      sided_q[0] <= side1_q;
      for (int i = 1; i < DIV_LAT; i++) sided_q[i] <= sided_q[i-1];
    end
  end

  // narrow the interval by one axis
  function automatic ivl_t axis_comb(ivl_t cur, logic signed [QW-1:0] qa,
                                     logic signed [QW-1:0] qb, logic dz,
                                     logic pass);
    ivl_t                 r;
    logic signed [QW-1:0] a, b;
    r = cur;
    if (qa > qb) begin
      a = qb;
      b = qa;
    end else begin
      a = qa;
      b = qb;
    end
    if (dz) begin
      r.ok = cur.ok && pass;
    end else if (cur.enter > b || a > cur.leave) begin
      r.ok = 1'b0;
    end else begin
      r.ok    = cur.ok;
      r.enter = (a > cur.enter) ? a : cur.enter;
      r.leave = (b < cur.leave) ? b : cur.leave;
    end
    return r;
  endfunction

  // ---------------- x axis ----------------
  ivl_t ivl0, ivlx_d, ivlx_q;
  logic v2_q;
  logic signed [QW-1:0] qyl_q, qyh_q;
  logic dz_y_q, pass_y_q;

  always_comb begin
    ivl0.ok    = 1'b1;
    ivl0.enter = '0;
    ivl0.leave = QW'(1) <<< FB;
    ivlx_d = axis_comb(ivl0, quo[0], quo[1], sided_q[DIV_LAT-1].dz_x,
                       sided_q[DIV_LAT-1].pass_x);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else if (adv) begin
      v2_q <= vd_q[DIV_LAT-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      ivlx_q   <= ivlx_d;
      qyl_q    <= quo[2];
      qyh_q    <= quo[3];
      dz_y_q   <= sided_q[DIV_LAT-1].dz_y;
      pass_y_q <= sided_q[DIV_LAT-1].pass_y;
    end
  end

  // ---------------- y axis and output word ----------------
  ivl_t ivly;
  out_t out_d, out_q;

  always_comb begin
    ivly = axis_comb(ivlx_q, qyl_q, qyh_q, dz_y_q, pass_y_q);
    out_d.hit         = ivly.ok;
    out_d.entry_param = ivly.ok ? ivly.enter[FB:0] : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule
